// ===== src/sst_pkg.sv =====
// sst_pkg: widths, command codes and sequencer states for subset_sum_transform.
// No dependencies.
`default_nettype none

package sst_pkg;

    localparam int COUNT_W       = 32;
    localparam int MASK_VALUE_W  = 10;
    localparam int CMD_W         = 2;
    localparam int MASK_BITS_DEF = 10;
    localparam int MASK_BITS_MAX = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 2'd0,
        CMD_TRANSFORM = 2'd1,
        CMD_QUERY     = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_INS,
        ST_QRY,
        ST_TF_RD,
        ST_TF_WR,
        ST_CLR,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/sst_req_if.sv =====
// sst_req_if: request channel (command, mask_value) with valid/ready.
// Depends on sst_pkg.
`default_nettype none

interface sst_req_if import sst_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [MASK_VALUE_W-1:0] mask_value;

    modport source (output valid, output command, output mask_value, input ready);
    modport sink   (input valid, input command, input mask_value, output ready);
endinterface

`default_nettype wire

// ===== src/sst_rsp_if.sv =====
// sst_rsp_if: response channel (subset_count, saturated) with valid/ready.
// Depends on sst_pkg.
`default_nettype none

interface sst_rsp_if import sst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] subset_count;
    logic               saturated;

    modport source (output valid, output subset_count, output saturated, input ready);
    modport sink   (input valid, input subset_count, input saturated, output ready);
endinterface

`default_nettype wire

// ===== src/sst_ram.sv =====
// sst_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== src/sst_satadd.sv =====
// sst_satadd: shared saturating adder for count updates.
// Depends on sst_pkg for the default width.
`default_nettype none

module sst_satadd import sst_pkg::*; #(
    parameter int WIDTH = COUNT_W
) (
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    output logic      [WIDTH-1:0] o_sum,
    output logic                  o_sat
);

    logic [WIDTH:0] sum_ext;

    assign sum_ext = {1'b0, i_a} + {1'b0, i_b};
    assign o_sat   = sum_ext[WIDTH];
    assign o_sum   = sum_ext[WIDTH] ? {WIDTH{1'b1}} : sum_ext[WIDTH-1:0];

endmodule

`default_nettype wire

// ===== src/subset_sum_transform.sv =====
// subset_sum_transform: histogram table with in-place sum-over-subsets transform.
// Depends on sst_pkg, sst_req_if, sst_rsp_if, sst_ram, sst_satadd.
//
//  channel  dir  beat fields                   notes
//  i_req    in   command, mask_value           ready only when sequencer idle
//  o_rsp    out  subset_count, saturated       one beat per request, registered
//
// Insert and query: registered RAM read, then update or capture.
// Transform: one read/add/write per update through the single saturating adder.
// Clear: one entry a cycle.
// After reset all 2^MASK_BITS entries are swept to zero; i_req is not ready meanwhile.
// A stalled o_rsp holds one finished result; the next request is still taken.
`default_nettype none

module subset_sum_transform import sst_pkg::*; #(
    parameter int MASK_BITS = MASK_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sst_req_if.sink    i_req,
    sst_rsp_if.source  o_rsp
);

    localparam int AW = MASK_BITS;
    localparam int BW = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;
    localparam logic [AW-1:0] K_LAST   = AW'((1 << (MASK_BITS - 1)) - 1);
    localparam logic [BW-1:0] BIT_LAST = BW'(MASK_BITS - 1);

    t_state r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_k, n_k;
    logic [BW-1:0]      r_bit, n_bit;
    logic               r_ovf, n_ovf;
    logic [COUNT_W-1:0] r_res, n_res;
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic               r_out_sat, n_out_sat;

    logic [MASK_BITS_MAX+MASK_VALUE_W-1:0] mv_ext;
    logic [AW-1:0]      idx_in;
    logic [AW-1:0]      tf_m, tf_p;
    logic [AW-1:0]      bit_sel, low_sel;
    logic               req_acc, out_free, fin, tf_last;
    logic [COUNT_W-1:0] fin_res;

    logic               we;
    logic [AW-1:0]      waddr, raddr_a, raddr_b;
    logic [COUNT_W-1:0] wdata, rdata_a, rdata_b;
    logic [COUNT_W-1:0] add_b, sum;
    logic               sat;

    assign mv_ext   = {{MASK_BITS_MAX{1'b0}}, i_req.mask_value};
    assign idx_in   = mv_ext[AW-1:0];
    assign req_acc  = (r_state == ST_IDLE) && i_req.valid;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign tf_last  = (r_k == K_LAST) && (r_bit == BIT_LAST);

    // mask with the current bit set, remaining bits from the counter; partner clears it
    assign bit_sel = AW'(1) << r_bit;
    assign low_sel = bit_sel - AW'(1);
    assign tf_m    = ((r_k << 1) & ~low_sel) | (r_k & low_sel) | bit_sel;
    assign tf_p    = tf_m & ~bit_sel;

    sst_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (1 << MASK_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    sst_satadd #(
        .WIDTH (COUNT_W)
    ) u_add (
        .i_a   (rdata_a),
        .i_b   (add_b),
        .o_sum (sum),
        .o_sat (sat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (&r_k) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    case (t_cmd'(i_req.command))
                        CMD_INSERT:    n_state = ST_INS;
                        CMD_TRANSFORM: n_state = ST_TF_RD;
                        CMD_QUERY:     n_state = ST_QRY;
                        CMD_CLEAR:     n_state = ST_CLR;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INS, ST_QRY: begin
                n_state = out_free ? ST_IDLE : ST_DONE;
            end
            ST_TF_RD: begin
                n_state = ST_TF_WR;
            end
            ST_TF_WR: begin
                if (tf_last) begin
                    n_state = out_free ? ST_IDLE : ST_DONE;
                end else begin
                    n_state = ST_TF_RD;
                end
            end
            ST_CLR: begin
                if (&r_k) n_state = out_free ? ST_IDLE : ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_k     = r_k;
        n_bit   = r_bit;
        n_ovf   = r_ovf;
        n_res   = r_res;
        we      = 1'b0;
        waddr   = r_idx;
        wdata   = sum;
        raddr_a = r_idx;
        raddr_b = tf_p;
        add_b   = COUNT_W'(1);
        fin     = 1'b0;
        fin_res = '0;
        case (r_state)
            ST_INIT: begin
                we    = 1'b1;
                waddr = r_k;
                wdata = '0;
                n_k   = r_k + AW'(1);
            end
            ST_IDLE: begin
                raddr_a = idx_in;
                if (req_acc) begin
                    n_idx = idx_in;
                    n_k   = '0;
                    n_bit = '0;
                    if (t_cmd'(i_req.command) == CMD_CLEAR) n_ovf = 1'b0;
                end
            end
            ST_INS: begin
                we    = 1'b1;
                n_ovf = r_ovf | sat;
                fin   = 1'b1;
            end
            ST_QRY: begin
                fin     = 1'b1;
                fin_res = rdata_a;
            end
            ST_TF_RD: begin
                raddr_a = tf_m;
            end
            ST_TF_WR: begin
                add_b = rdata_b;
                we    = 1'b1;
                waddr = tf_m;
                n_ovf = r_ovf | sat;
                if (r_k == K_LAST) begin
                    n_k = '0;
                    if (r_bit == BIT_LAST) begin
                        fin = 1'b1;
                    end else begin
                        n_bit = r_bit + BW'(1);
                    end
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            ST_CLR: begin
                we    = 1'b1;
                waddr = r_k;
                wdata = '0;
                n_k   = r_k + AW'(1);
                if (&r_k) fin = 1'b1;
            end
            default: begin
            end
        endcase
        if (fin && !out_free) n_res = fin_res;
    end

    // output holding register
    always_comb begin
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_count = r_out_count;
        n_out_sat   = r_out_sat;
        if (fin && out_free) begin
            n_out_valid = 1'b1;
            n_out_count = fin_res;
            n_out_sat   = n_ovf;
        end else if ((r_state == ST_DONE) && out_free) begin
            n_out_valid = 1'b1;
            n_out_count = r_res;
            n_out_sat   = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_k         <= '0;
            r_bit       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_bit       <= n_bit;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_res       <= n_res;
        r_out_count <= n_out_count;
        r_out_sat   <= n_out_sat;
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.subset_count = r_out_count;
    assign o_rsp.saturated    = r_out_sat;

endmodule

`default_nettype wire
